### hdl/mrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;
   localparam int MaxLeaves = 1024;
   localparam int AddrW = $clog2(MaxLeaves);
   localparam int CountW = AddrW + 1;
   localparam logic OP_LEAF = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef logic [63:0] word_type;
   typedef logic [255:0] hash_type;

   typedef struct packed {
      logic start;
      hash_type left;
      hash_type right;
   } sha_req_type;

   typedef struct packed {
      logic done;
      hash_type digest;
   } sha_rsp_type;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [255:0] H_INIT = {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

### hdl/mrs_sha.sv
`timescale 1ns / 1ps
`default_nettype none
module mrs_sha
   import mrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sha_req_type req,
   output sha_rsp_type      rsp
);
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [255:0] st_ff, st_in;
   logic [6:0] rnd_ff, rnd_in;
   logic blk_ff, blk_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [31:0] wt, s0, s1, t1, t2, wa, wb, ve, va;
   logic [255:0] st_sum;

   always_comb begin
      wa = w_ff[1];
      wb = w_ff[14];
      s0 = rotr(wa, 7) ^ rotr(wa, 18) ^ (wa >> 3);
      s1 = rotr(wb, 17) ^ rotr(wb, 19) ^ (wb >> 10);
      wt = (rnd_ff < 7'd16) ? w_ff[0] : (w_ff[0] + s0 + w_ff[9] + s1);
      ve = v_ff[4];
      va = v_ff[0];
      t1 = v_ff[7] + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
         + ((ve & v_ff[5]) ^ (~ve & v_ff[6])) + K_TAB[rnd_ff[5:0]] + wt;
      t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
         + ((va & v_ff[1]) ^ (va & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      for (int i = 0; i < 8; i++) begin
         st_sum[255 - 32*i -: 32] = st_ff[255 - 32*i -: 32] + v_ff[i];
      end
   end

   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      st_in = st_ff;
      rnd_in = rnd_ff;
      blk_in = blk_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         for (int i = 0; i < 8; i++) begin
            w_in[i] = req.left[255 - 32*i -: 32];
            w_in[8 + i] = req.right[255 - 32*i -: 32];
            v_in[i] = H_INIT[255 - 32*i -: 32];
         end
         st_in = H_INIT;
         rnd_in = '0;
         blk_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rnd_ff == 7'd64) begin
            if (!blk_ff) begin
               for (int i = 0; i < 16; i++) w_in[i] = '0;
               w_in[0] = 32'h80000000;
               w_in[15] = 32'd512;
               for (int i = 0; i < 8; i++) v_in[i] = st_sum[255 - 32*i -: 32];
               st_in = st_sum;
               rnd_in = '0;
               blk_in = 1'b1;
            end else begin
               st_in = st_sum;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = wt;
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in = rnd_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      st_ff <= st_in;
      if (reset) begin
         rnd_ff <= '0;
         blk_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         rnd_ff <= rnd_in;
         blk_ff <= blk_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.digest = st_ff;
endmodule
`default_nettype wire

### hdl/merkle_root_sha256.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata                         | tuser     | tlast
// req     | in  | leaf_word[63:0]               | op        | -
// rsp     | out | root_word[63:0]               | overflow  | root_last
// leaf words are taken while loading, four to a 256-bit leaf that the fourth word
// writes into the leaf store; a finish hashes each pair (two sha blocks plus
// store reads of the left and right nodes and a write of the digest) over all tree
// levels, then sends four output items; synchronous reset clears counts and control, not the store
// rsp stalls hold the finish state; no new item is taken until the root leaves
module merkle_root_sha256
   import mrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // leaf_word
   input  wire logic        req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // root_word
   output logic             rsp_tuser,  // overflow
   output logic             rsp_tlast   // root_last
);
   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001,
      S_RDL   = 7'b0000010,
      S_RDR   = 7'b0000100,
      S_WAITR = 7'b0001000,
      S_HASH  = 7'b0010000,
      S_RDRT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   hash_type mem [MaxLeaves];
   hash_type rd_ff;
   logic [AddrW-1:0] rd_addr;
   logic we;
   logic [AddrW-1:0] wr_addr;
   hash_type wr_data;

   state_type st_ff, st_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [1:0] pos_ff, pos_in;
   logic ovf_ff, ovf_in;
   hash_type part_ff, part_in;
   logic [CountW-1:0] n_ff, n_in;
   logic [CountW-1:0] i_ff, i_in;
   hash_type left_ff, left_in, root_ff, root_in;
   logic rz_ff, rz_in;
   logic [1:0] ow_ff, ow_in;
   sha_req_type sreq;
   sha_rsp_type srsp;
   logic [CountW-1:0] li, ri, half;

   mrs_sha u_sha (.clock(clock), .reset(reset), .req(sreq), .rsp(srsp));

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      li = {i_ff[CountW-2:0], 1'b0};
      ri = li + 1'b1;
      half = (n_ff >> 1) + {{(CountW-1){1'b0}}, n_ff[0]};
      st_in = st_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      part_in = part_ff;
      n_in = n_ff;
      i_in = i_ff;
      left_in = left_ff;
      root_in = root_ff;
      rz_in = rz_ff;
      ow_in = ow_ff;
      we = 1'b0;
      wr_addr = cnt_ff[AddrW-1:0];
      wr_data = {part_ff[255:64], req_tdata};
      rd_addr = li[AddrW-1:0];
      sreq.start = 1'b0;
      sreq.left = left_ff;
      sreq.right = rz_ff ? '0 : rd_ff;
      req_tready = (st_ff == S_LOAD);
      case (st_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (req_tuser == OP_LEAF) begin
                  if (cnt_ff == CountW'(MaxLeaves)) begin
                     ovf_in = 1'b1;
                  end else begin
                     case (pos_ff)
                        2'd0: part_in[255:192] = req_tdata;
                        2'd1: part_in[191:128] = req_tdata;
                        2'd2: part_in[127:64] = req_tdata;
                        default: begin
                           we = 1'b1;
                           cnt_in = cnt_ff + 1'b1;
                        end
                     endcase
                     pos_in = pos_ff + 2'd1;
                  end
               end else begin
                  n_in = cnt_ff;
                  i_in = '0;
                  if (cnt_ff == '0) begin
                     root_in = '0;
                     st_in = S_OUT;
                     ow_in = '0;
                  end else if (cnt_ff == CountW'(1)) begin
                     st_in = S_RDRT;
                  end else begin
                     st_in = S_RDL;
                  end
               end
            end
         end
         S_RDL: begin
            rd_addr = li[AddrW-1:0];
            st_in = S_RDR;
         end
         S_RDR: begin
            rd_addr = ri[AddrW-1:0];
            left_in = rd_ff;
            rz_in = (ri >= n_ff);
            st_in = S_WAITR;
         end
         S_WAITR: begin
            sreq.start = 1'b1;
            st_in = S_HASH;
         end
         S_HASH: begin
            if (srsp.done) begin
               we = 1'b1;
               wr_addr = i_ff[AddrW-1:0];
               wr_data = srsp.digest;
               if (i_ff + 1'b1 == half) begin
                  n_in = half;
                  i_in = '0;
                  st_in = (half == CountW'(1)) ? S_RDRT : S_RDL;
               end else begin
                  i_in = i_ff + 1'b1;
                  st_in = S_RDL;
               end
            end
         end
         S_RDRT: begin
            rd_addr = '0;
            if (rz_ff) begin
               root_in = rd_ff;
               rz_in = 1'b0;
               ow_in = '0;
               st_in = S_OUT;
            end else begin
               rz_in = 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               ow_in = ow_ff + 2'd1;
               if (ow_ff == 2'd3) begin
                  cnt_in = '0;
                  pos_in = '0;
                  ovf_in = 1'b0;
                  st_in = S_LOAD;
               end
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      n_ff <= n_in;
      i_ff <= i_in;
      left_ff <= left_in;
      root_ff <= root_in;
      if (reset) begin
         st_ff <= S_LOAD;
         cnt_ff <= '0;
         pos_ff <= '0;
         ovf_ff <= 1'b0;
         rz_ff <= 1'b0;
         ow_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
         rz_ff <= rz_in;
         ow_ff <= ow_in;
      end
   end

   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tuser = ovf_ff;
   assign rsp_tlast = (ow_ff == 2'd3);
   always_comb begin
      case (ow_ff)
         2'd0: rsp_tdata = root_ff[255:192];
         2'd1: rsp_tdata = root_ff[191:128];
         2'd2: rsp_tdata = root_ff[127:64];
         default: rsp_tdata = root_ff[63:0];
      endcase
   end
endmodule
`default_nettype wire
